FILE: sv/pfe_pkg.sv
`timescale 1ns / 1ps

package pfe_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned Q_DEPTH     = 2;
  localparam int unsigned DIV_STEPS   = 32;

  localparam logic [7:0] SYM_ADD = 8'h2B;
  localparam logic [7:0] SYM_SUB = 8'h2D;
  localparam logic [7:0] SYM_MUL = 8'h2A;
  localparam logic [7:0] SYM_DIV = 8'h2F;
  localparam logic [7:0] SYM_NUL = 8'h00;
  localparam logic [7:0] SYM_LF  = 8'h0A;
  localparam logic [8:0] DIGIT_BASE = 9'd48;

  typedef enum logic [2:0] {
    K_PUSH,
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV,
    K_END
  } pfe_kind_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_UNDERFLOW,
    ST_OVERFLOW,
    ST_DIVZERO
  } pfe_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_EXEC,
    S_DIV,
    S_WB,
    S_FIN
  } pfe_state_e;

  // Classified symbol: kind plus signed literal (code minus 48).
  typedef struct packed {
    pfe_kind_e         kind;
    logic signed [8:0] lit;
  } pfe_cmd_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } pfe_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } pfe_div_rsp_t;

  // First error wins.
  function automatic pfe_status_e note_err(pfe_status_e cur, pfe_status_e code);
    return (cur == ST_OK) ? code : cur;
  endfunction

endpackage

FILE: sv/pfe_if.sv
`timescale 1ns / 1ps

interface pfe_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface pfe_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic        [1:0]  status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

FILE: sv/postfix_expression_evaluator_unit.sv
`timescale 1ns / 1ps

// Postfix (RPN) evaluator on a value stack.
// Channel in_i carries one expression byte per beat (symbol). Channel out_o
// carries one beat per terminator (byte 0 or 10): result_value and status
// (0 ok, 1 underflow, 2 overflow, 3 divide by zero; first error wins).
// The front classifies each byte and drops it into a two-entry queue; the
// back runs it against the stack memory, so bytes are taken while the back
// is still busy until the queue fills.
// Steps per byte in the back: a pushed value is written to the stack;
// + - * do two registered stack reads, execute, write back; / adds the
// 32-step radix-2 divider before write back, unless the divisor is
// zero; a terminator on an empty stack gives its result directly, else
// after one stack read.
// Reset clears the stack count, the error status, the queue and the
// result valid flag; no clearing pass over the stack memory.
// When the receiver stalls, the result waits in the output register;
// pushes and operators go on, and only the next terminator waits.
module postfix_expression_evaluator_unit #(
  parameter int unsigned STACK_DEPTH = pfe_pkg::STACK_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfe_sym_if.sink   in_i,
  pfe_res_if.source out_o
);

  // front -> queue
  logic              push;
  logic              full;
  pfe_pkg::pfe_cmd_t push_cmd;

  // queue -> back
  logic              q_valid;
  logic              q_pop;
  pfe_pkg::pfe_cmd_t q_cmd;

  // back <-> divider
  pfe_pkg::pfe_div_req_t div_req;
  pfe_pkg::pfe_div_rsp_t div_rsp;

  pfe_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  pfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  pfe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pfe_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp),
    .out_o     (out_o)
  );

endmodule

FILE: sv/pfe_front.sv
`timescale 1ns / 1ps

module pfe_front (
  pfe_sym_if.sink           in_i,
  input  logic              full_i,
  output logic              push_o,
  output pfe_pkg::pfe_cmd_t cmd_o
);

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    cmd_o.lit = $signed({1'b0, in_i.symbol} - pfe_pkg::DIGIT_BASE);
    case (in_i.symbol)
      pfe_pkg::SYM_ADD: cmd_o.kind = pfe_pkg::K_ADD;
      pfe_pkg::SYM_SUB: cmd_o.kind = pfe_pkg::K_SUB;
      pfe_pkg::SYM_MUL: cmd_o.kind = pfe_pkg::K_MUL;
      pfe_pkg::SYM_DIV: cmd_o.kind = pfe_pkg::K_DIV;
      pfe_pkg::SYM_NUL: cmd_o.kind = pfe_pkg::K_END;
      pfe_pkg::SYM_LF:  cmd_o.kind = pfe_pkg::K_END;
      default:          cmd_o.kind = pfe_pkg::K_PUSH;
    endcase
  end

endmodule

FILE: sv/pfe_queue.sv
`timescale 1ns / 1ps

module pfe_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pfe_pkg::pfe_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output pfe_pkg::pfe_cmd_t cmd_o
);

  localparam int unsigned QD  = pfe_pkg::Q_DEPTH;
  localparam int unsigned QAW = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned QCW = $clog2(QD + 1);

  pfe_pkg::pfe_cmd_t slot_q [QD];
  logic [QAW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == QCW'(QD));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == QAW'(QD - 1)) ? '0 : wptr_q + QAW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QAW'(QD - 1)) ? '0 : rptr_q + QAW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + QCW'(1);
      2'b01:   cnt_d = cnt_q - QCW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

endmodule

FILE: sv/pfe_div.sv
`timescale 1ns / 1ps

module pfe_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pfe_pkg::pfe_div_req_t req_i,
  output pfe_pkg::pfe_div_rsp_t rsp_o
);

  localparam int unsigned SW = $clog2(pfe_pkg::DIV_STEPS);

  logic          busy_q, busy_d, done_q, done_d;
  logic [SW-1:0] step_q, step_d;
  logic [31:0]   rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic          neg_q, neg_d;
  logic [32:0]   trial;
  logic [32:0]   diff;
  logic          ge;

  // Restoring division on magnitudes, one quotient bit per cycle.
  assign trial = {rem_q, quo_q[31]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = req_i.num[31] ? (32'd0 - req_i.num) : req_i.num;
      den_d  = req_i.den[31] ? (32'd0 - req_i.den) : req_i.den;
      neg_d  = req_i.num[31] ^ req_i.den[31];
    end else if (busy_q) begin
      rem_d  = ge ? diff[31:0] : trial[31:0];
      quo_d  = {quo_q[30:0], ge};
      step_d = step_q + SW'(1);
      if (step_q == SW'(pfe_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

FILE: sv/pfe_back.sv
`timescale 1ns / 1ps

module pfe_back #(
  parameter int unsigned STACK_DEPTH = pfe_pkg::STACK_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  pfe_pkg::pfe_cmd_t     q_cmd_i,
  output logic                  q_pop_o,
  output pfe_pkg::pfe_div_req_t div_req_o,
  input  pfe_pkg::pfe_div_rsp_t div_rsp_i,
  pfe_res_if.source             out_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  pfe_pkg::pfe_state_e  state_q, state_d;
  pfe_pkg::pfe_status_e err_q, err_d;
  pfe_pkg::pfe_kind_e   op_q, op_d;
  logic [CW-1:0]        count_q, count_d, cm1, cm2;
  logic [31:0]          stack_q [STACK_DEPTH];
  logic [31:0]          rdata_q;
  logic [AW-1:0]        raddr, waddr;
  logic [31:0]          wdata;
  logic                 we;
  logic [31:0]          first_q, first_d, second_q, second_d, res_q, res_d;

  logic                 out_valid_q, out_valid_d;
  logic signed [31:0]   out_val_q, out_val_d;
  pfe_pkg::pfe_status_e out_st_q, out_st_d;
  logic                 load;
  logic                 out_free;
  pfe_pkg::pfe_status_e e;

  assign cm1      = count_q - CW'(1);
  assign cm2      = count_q - CW'(2);
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d   = state_q;
    err_d     = err_q;
    op_d      = op_q;
    count_d   = count_q;
    first_d   = first_q;
    second_d  = second_q;
    res_d     = res_q;
    raddr     = cm1[AW-1:0];
    waddr     = count_q[AW-1:0];
    wdata     = '0;
    we        = 1'b0;
    q_pop_o   = 1'b0;
    load      = 1'b0;
    out_val_d = out_val_q;
    out_st_d  = out_st_q;
    div_req_o = '0;
    e         = err_q;
    case (state_q)
      pfe_pkg::S_IDLE: begin
        if (q_valid_i) begin
          case (q_cmd_i.kind)
            pfe_pkg::K_PUSH: begin
              q_pop_o = 1'b1;
              if (count_q == CW'(STACK_DEPTH)) begin
                err_d = pfe_pkg::note_err(err_q, pfe_pkg::ST_OVERFLOW);
              end else begin
                we      = 1'b1;
                wdata   = {{23{q_cmd_i.lit[8]}}, q_cmd_i.lit};
                count_d = count_q + CW'(1);
              end
            end
            pfe_pkg::K_ADD, pfe_pkg::K_SUB, pfe_pkg::K_MUL, pfe_pkg::K_DIV: begin
              q_pop_o = 1'b1;
              op_d    = q_cmd_i.kind;
              state_d = pfe_pkg::S_RD1;
            end
            pfe_pkg::K_END: begin
              if (out_free) begin
                q_pop_o = 1'b1;
                if (count_q == '0) begin
                  // empty final pop: -1 and underflow
                  load      = 1'b1;
                  out_val_d = -32'sd1;
                  out_st_d  = pfe_pkg::note_err(err_q, pfe_pkg::ST_UNDERFLOW);
                  err_d     = pfe_pkg::ST_OK;
                end else begin
                  state_d = pfe_pkg::S_FIN;
                end
              end
            end
            default: begin
              q_pop_o = 1'b1;
            end
          endcase
        end
      end
      pfe_pkg::S_RD1: begin
        first_d = (count_q >= CW'(1)) ? rdata_q : '1;
        raddr   = cm2[AW-1:0];
        state_d = pfe_pkg::S_RD2;
      end
      pfe_pkg::S_RD2: begin
        second_d = (count_q >= CW'(2)) ? rdata_q : '1;
        state_d  = pfe_pkg::S_EXEC;
      end
      pfe_pkg::S_EXEC: begin
        if (count_q < CW'(2)) begin
          e = pfe_pkg::note_err(err_q, pfe_pkg::ST_UNDERFLOW);
        end
        state_d = pfe_pkg::S_WB;
        case (op_q)
          pfe_pkg::K_ADD: res_d = second_q + first_q;
          pfe_pkg::K_SUB: res_d = second_q - first_q;
          pfe_pkg::K_MUL: res_d = second_q * first_q;
          pfe_pkg::K_DIV: begin
            if (first_q == '0) begin
              res_d = '0;
              e     = pfe_pkg::note_err(e, pfe_pkg::ST_DIVZERO);
            end else begin
              div_req_o.start = 1'b1;
              div_req_o.num   = second_q;
              div_req_o.den   = first_q;
              state_d         = pfe_pkg::S_DIV;
            end
          end
          default: res_d = res_q;
        endcase
        err_d = e;
      end
      pfe_pkg::S_DIV: begin
        if (div_rsp_i.done) begin
          res_d   = div_rsp_i.quot;
          state_d = pfe_pkg::S_WB;
        end
      end
      pfe_pkg::S_WB: begin
        // two pops then one push
        we      = 1'b1;
        wdata   = res_q;
        waddr   = (count_q >= CW'(2)) ? cm2[AW-1:0] : '0;
        count_d = (count_q >= CW'(2)) ? cm1 : CW'(1);
        state_d = pfe_pkg::S_IDLE;
      end
      pfe_pkg::S_FIN: begin
        load      = 1'b1;
        out_val_d = $signed(rdata_q);
        out_st_d  = err_q;
        err_d     = pfe_pkg::ST_OK;
        count_d   = '0;
        state_d   = pfe_pkg::S_IDLE;
      end
      default: state_d = pfe_pkg::S_IDLE;
    endcase
    if (load) begin
      count_d = '0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfe_pkg::S_IDLE;
      err_q       <= pfe_pkg::ST_OK;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    first_q   <= first_d;
    second_q  <= second_d;
    res_q     <= res_d;
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      stack_q[waddr] <= wdata;
    end
    rdata_q <= stack_q[raddr];
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_val_q;
  assign out_o.status       = out_st_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || out_o.ready))
    else $error("result register overwritten before its beat");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> (state_q == pfe_pkg::S_DIV))
    else $error("quotient arrived while not waiting for it");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("queue popped while empty");

endmodule
